FILE: sv/glt_pkg.sv
// Shared types, codes and helpers for the glyph lookup text layout block.
// No dependencies; imported by every module of the block.
`default_nettype none
package glt_pkg;

  localparam logic [1:0] CMD_LOAD_CODE    = 2'd0;
  localparam logic [1:0] CMD_LOAD_METRICS = 2'd1;
  localparam logic [1:0] CMD_PLACE        = 2'd2;
  localparam logic [1:0] CMD_RESET_PEN    = 2'd3;

  localparam logic [15:0] NEWLINE_CODE = 16'd10;

  localparam logic [2:0] CFG_START_X     = 3'd0;
  localparam logic [2:0] CFG_START_Y     = 3'd1;
  localparam logic [2:0] CFG_LINE_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_GLYPH_COUNT = 3'd3;
  localparam logic [2:0] CFG_FALLBACK    = 3'd4;
  localparam logic [2:0] CFG_WRAP_LIMIT  = 3'd5;

  typedef struct packed {
    logic signed [9:0] start_x;
    logic signed [9:0] start_y;
    logic [7:0]        line_height;
    logic [12:0]       glyph_count;
    logic [11:0]       fallback_glyph;
    logic [9:0]        wrap_limit;
  } glt_cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic bs_rd;
    logic bs_step;
    logic ls_init;
    logic ls_rd;
    logic ls_step;
    logic take_probe;
    logic use_fb;
    logic mt_rd;
    logic emit;
  } glt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic place_glyph;
    logic bs_live;
    logic ls_live;
    logic code_eq;
  } glt_stat_t;

  function automatic logic signed [10:0] sat11(input logic signed [12:0] v);
    if (v < -13'sd1024) begin
      return -11'sd1024;
    end else if (v > 13'sd1023) begin
      return 11'sd1023;
    end else begin
      return v[10:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: sv/glt_cfg.sv
// Configuration register file of the glyph lookup text layout block.
// Depends on glt_pkg for the register codes and the config struct.
`default_nettype none
module glt_cfg
  import glt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr,
  input  wire logic [2:0]  index,
  input  wire logic [12:0] data,
  output glt_cfg_t         cfg
);

  glt_cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_x        <= 10'sd0;
      regs.start_y        <= 10'sd0;
      regs.line_height    <= 8'd16;
      regs.glyph_count    <= 13'd0;
      regs.fallback_glyph <= 12'd0;
      regs.wrap_limit     <= 10'd256;
    end else if (wr) begin
      case (index)
        CFG_START_X:     regs.start_x        <= data[9:0];
        CFG_START_Y:     regs.start_y        <= data[9:0];
        CFG_LINE_HEIGHT: regs.line_height    <= data[7:0];
        CFG_GLYPH_COUNT: regs.glyph_count    <= data;
        CFG_FALLBACK:    regs.fallback_glyph <= data[11:0];
        CFG_WRAP_LIMIT:  regs.wrap_limit     <= data[9:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule
`default_nettype wire

FILE: sv/glt_ctrl.sv
// Sequencer of the glyph lookup text layout block: binary search, linear
// scan, metrics read and emit steps. Depends on glt_pkg for the command/status.
`default_nettype none
module glt_ctrl
  import glt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  glt_stat_t stat,
  output glt_cmd_t  cmd,
  output logic      busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BS_RD  = 3'd1;
  localparam logic [2:0] S_BS_CMP = 3'd2;
  localparam logic [2:0] S_LS_RD  = 3'd3;
  localparam logic [2:0] S_LS_CMP = 3'd4;
  localparam logic [2:0] S_MT_RD  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (stat.place_glyph) state_next = S_BS_RD;
        end
      end
      S_BS_RD: begin
        if (stat.bs_live) begin
          cmd.bs_rd  = 1'b1;
          state_next = S_BS_CMP;
        end else begin
          cmd.ls_init = 1'b1;
          state_next  = S_LS_RD;
        end
      end
      S_BS_CMP: begin
        if (stat.code_eq) begin
          cmd.take_probe = 1'b1;
          state_next     = S_MT_RD;
        end else begin
          cmd.bs_step = 1'b1;
          state_next  = S_BS_RD;
        end
      end
      S_LS_RD: begin
        if (stat.ls_live) begin
          cmd.ls_rd  = 1'b1;
          state_next = S_LS_CMP;
        end else begin
          cmd.use_fb = 1'b1;
          state_next = S_MT_RD;
        end
      end
      S_LS_CMP: begin
        if (stat.code_eq) begin
          cmd.take_probe = 1'b1;
          state_next     = S_MT_RD;
        end else begin
          cmd.ls_step = 1'b1;
          state_next  = S_LS_RD;
        end
      end
      S_MT_RD: begin
        cmd.mt_rd  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

FILE: sv/glt_dp.sv
// Datapath of the glyph lookup text layout block: code and metrics memories,
// search bounds, pen registers and the result register. Depends on glt_pkg.
`default_nettype none
module glt_dp
  import glt_pkg::*;
#(
  parameter int MAX_GLYPHS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  glt_cfg_t         cfg,
  input  glt_cmd_t         cmd,
  output glt_stat_t        stat,
  input  wire logic [1:0]  command,
  input  wire logic [11:0] slot,
  input  wire logic [15:0] code,
  input  wire logic [7:0]  left_bearing,
  input  wire logic [7:0]  advance,
  output logic             done,
  output logic [11:0]      glyph,
  output logic             found,
  output logic signed [10:0] draw_x,
  output logic signed [10:0] draw_y
);

  localparam int AW = $clog2(MAX_GLYPHS);
  localparam int CW = $clog2(MAX_GLYPHS + 1);
  localparam int GW = (AW > 12) ? AW : 12;
  localparam logic signed [CW:0] ONE_S = (CW+1)'(1);

  logic [15:0] code_mem [MAX_GLYPHS];
  logic [15:0] metr_mem [MAX_GLYPHS];   // {bearing, advance}

  logic [15:0]        code_rdata;
  logic [15:0]        metr_rdata;
  logic [AW-1:0]      code_raddr;
  logic [15:0]        code_q;
  logic signed [CW:0] lo;
  logic signed [CW:0] hi;
  logic signed [CW:0] mid_full;
  logic [CW-1:0]      lin;
  logic [AW-1:0]      probe;
  logic [GW-1:0]      gidx;
  logic               hit;
  logic               mt_ok;
  logic signed [10:0] pen_x;
  logic signed [10:0] pen_y;

  logic [31:0]        gc32;
  logic [CW-1:0]      n;
  logic [GW-1:0]      slot_g;
  logic               slot_ok;
  logic               load_code_wr;
  logic               load_metr_wr;
  logic signed [10:0] sx11;
  logic signed [10:0] sy11;
  logic signed [10:0] py_down;
  logic               wrap;
  logic signed [10:0] px_w;
  logic signed [10:0] py_w;
  logic [7:0]         bear;
  logic [7:0]         adv;
  logic signed [CW:0] probe_s;

  // entries in use, clamped to the table size
  assign gc32 = 32'(cfg.glyph_count);
  assign n    = (gc32 > MAX_GLYPHS) ? CW'(MAX_GLYPHS) : gc32[CW-1:0];

  assign slot_g  = GW'(slot);
  assign slot_ok = (32'(slot) < MAX_GLYPHS);

  assign load_code_wr = cmd.accept && (command == CMD_LOAD_CODE) && slot_ok;
  assign load_metr_wr = cmd.accept && (command == CMD_LOAD_METRICS) && slot_ok;

  assign mid_full = lo + ((hi - lo) >>> 1);
  assign probe_s  = $signed({1'b0, CW'(probe)});

  always_comb begin
    if (cmd.bs_rd) begin
      code_raddr = mid_full[AW-1:0];
    end else begin
      code_raddr = lin[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_code_wr) code_mem[slot_g[AW-1:0]] <= code;
    if (cmd.bs_rd || cmd.ls_rd) code_rdata <= code_mem[code_raddr];
  end

  always_ff @(posedge clk) begin
    if (load_metr_wr) metr_mem[slot_g[AW-1:0]] <= {left_bearing, advance};
    if (cmd.mt_rd) metr_rdata <= metr_mem[gidx[AW-1:0]];
  end

  // search state
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      code_q <= code;
      lo     <= '0;
      hi     <= $signed({1'b0, n}) - ONE_S;
    end
    if (cmd.bs_rd) probe <= mid_full[AW-1:0];
    if (cmd.ls_rd) probe <= lin[AW-1:0];
    if (cmd.bs_step) begin
      if (code_rdata < code_q) begin
        lo <= probe_s + ONE_S;
      end else begin
        hi <= probe_s - ONE_S;
      end
    end
    if (cmd.ls_init) lin <= '0;
    if (cmd.ls_step) lin <= lin + 1'b1;
    if (cmd.take_probe) begin
      gidx <= GW'(probe);
      hit  <= 1'b1;
    end
    if (cmd.use_fb) begin
      gidx <= GW'(cfg.fallback_glyph);
      hit  <= 1'b0;
    end
    if (cmd.mt_rd) mt_ok <= (32'(gidx) < MAX_GLYPHS);
  end

  assign stat.place_glyph = (command == CMD_PLACE) && (code != NEWLINE_CODE);
  assign stat.bs_live     = (lo <= hi);
  assign stat.ls_live     = (lin < n);
  assign stat.code_eq     = (code_rdata == code_q);

  // pen arithmetic
  assign sx11    = 11'(cfg.start_x);
  assign sy11    = 11'(cfg.start_y);
  assign py_down = sat11($signed({{2{pen_y[10]}}, pen_y}) + $signed({5'b0, cfg.line_height}));
  assign wrap    = $signed({{2{pen_x[10]}}, pen_x}) > $signed({3'b0, cfg.wrap_limit});
  assign px_w    = wrap ? sx11 : pen_x;
  assign py_w    = wrap ? py_down : pen_y;
  assign bear    = mt_ok ? metr_rdata[15:8] : 8'd0;
  assign adv     = mt_ok ? metr_rdata[7:0] : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= 11'sd0;
      pen_y <= 11'sd0;
      done  <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.accept && (command == CMD_RESET_PEN)) begin
        pen_x <= sx11;
        pen_y <= sy11;
      end
      if (cmd.accept && (command == CMD_PLACE) && (code == NEWLINE_CODE)) begin
        pen_x <= sx11;
        pen_y <= py_down;
      end
      if (cmd.emit) begin
        pen_x <= sat11($signed({{2{px_w[10]}}, px_w}) + $signed({5'b0, adv}));
        pen_y <= py_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      glyph  <= gidx[11:0];
      found  <= hit;
      draw_x <= sat11($signed({{2{px_w[10]}}, px_w}) + $signed({5'b0, bear}));
      draw_y <= py_w;
    end
  end

endmodule
`default_nettype wire

FILE: sv/glyph_lookup_text_layout_top.sv
// Top level of the glyph lookup text layout block: config registers,
// sequencer and datapath. Depends on glt_pkg, glt_cfg, glt_ctrl and glt_dp.
`default_nettype none
// Requests enter on start/command/slot/code/left_bearing/advance and are
// taken on a clock edge with start high and busy low.
// Load code, load metrics, reset pen and newline finish at the accepting
// edge: busy stays low and no result is produced.
// A place request searches the code table: each binary search probe is a
// registered memory read, then a compare, for at most ceil(log2(n+1))
// probes; on a miss a linear scan follows, one read and compare per entry
// in use. The metrics read and the result register follow.
// The result (glyph, found, draw_x, draw_y) is shown for one cycle with done
// high; the receiver cannot stall. Busy is low in that cycle, so the next
// request can be taken at the edge that ends it.
// Config writes (cfg_valid, cfg_index, cfg_data) are always ready; the user
// must make them only while the block is idle: the block does not enforce it.
// Reset clears the pen and the sequencer and sets the config registers to
// their defaults; table contents are undefined until loaded.
module glyph_lookup_text_layout_top
  import glt_pkg::*;
#(
  parameter int MAX_GLYPHS = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [1:0]    command,
  input  wire logic [11:0]   slot,
  input  wire logic [15:0]   code,
  input  wire logic [7:0]    left_bearing,
  input  wire logic [7:0]    advance,
  output logic               done,
  output logic [11:0]        glyph,
  output logic               found,
  output logic signed [10:0] draw_x,
  output logic signed [10:0] draw_y,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [12:0]   cfg_data
);

  glt_cfg_t  cfg;
  glt_cmd_t  cmd;
  glt_stat_t stat;

  assign cfg_ready = 1'b1;

  glt_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr    (cfg_valid && cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  glt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  glt_dp #(
    .MAX_GLYPHS (MAX_GLYPHS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .command      (command),
    .slot         (slot),
    .code         (code),
    .left_bearing (left_bearing),
    .advance      (advance),
    .done         (done),
    .glyph        (glyph),
    .found        (found),
    .draw_x       (draw_x),
    .draw_y       (draw_y)
  );

`ifndef ASSERT_OFF
  // a result only follows a place request in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a place request in progress");

  // the block is idle again when the result is shown
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy still high with result strobe");

  // a glyph placement always starts the search sequence
  a_place_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command == CMD_PLACE) && (code != NEWLINE_CODE)) |=> busy)
    else $error("place request did not start a search");

  // load and pen-reset requests leave the block idle and produce no result
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command != CMD_PLACE)) |=> (!busy && !done))
    else $error("single-cycle request left the block busy");
`endif

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for glyph_lookup_text_layout_top: drives load, place,
// newline and pen-reset requests plus config writes, and predicts each placed
// glyph in a scoreboard class. Depends on glt_pkg and the block's RTL.
module testbench
  import glt_pkg::*;
();

  localparam int TABLE_DEPTH = 4096;
  localparam int STALL_LIMIT = 40000;
  localparam int LOG_LIMIT = 40;
  // writes here must be ignored by the block
  localparam logic [2:0] CFG_SPARE = 3'd6;

  class layout_scoreboard;
    typedef struct packed {
      logic [11:0]        glyph_idx;
      logic               hit;
      logic signed [10:0] col;
      logic signed [10:0] row;
    } placement_t;

    bit [15:0] code_tab [TABLE_DEPTH];
    bit [7:0]  bearing_tab [TABLE_DEPTH];
    bit [7:0]  advance_tab [TABLE_DEPTH];
    int pen_x = 0;
    int pen_y = 0;
    int org_x = 0;
    int org_y = 0;
    int line_h = 16;
    int glyph_count = 0;
    int fallback = 0;
    int wrap = 256;
    placement_t pending[$];
    int errors = 0;

    function int clamp_pos(input int v);
      if (v < -1024) return -1024;
      if (v > 1023) return 1023;
      return v;
    endfunction

    function void next_line();
      pen_x = org_x;
      pen_y = clamp_pos(pen_y + line_h);
    endfunction

    // binary search first, then a linear scan from entry 0
    function bit lookup(input bit [15:0] c, output int idx);
      int n, lo, hi, mid, i;
      n = (glyph_count > TABLE_DEPTH) ? TABLE_DEPTH : glyph_count;
      lo = 0;
      hi = n - 1;
      idx = 0;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (code_tab[mid] == c) begin
          idx = mid;
          return 1'b1;
        end
        if (code_tab[mid] < c) lo = mid + 1;
        else hi = mid - 1;
      end
      for (i = 0; i < n; i++) begin
        if (code_tab[i] == c) begin
          idx = i;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_config(input logic [2:0] idx, input logic [12:0] data);
      case (idx)
        CFG_START_X:     org_x = int'($signed(data[9:0]));
        CFG_START_Y:     org_y = int'($signed(data[9:0]));
        CFG_LINE_HEIGHT: line_h = int'(data[7:0]);
        CFG_GLYPH_COUNT: glyph_count = int'(data);
        CFG_FALLBACK:    fallback = int'(data[11:0]);
        CFG_WRAP_LIMIT:  wrap = int'(data[9:0]);
        default: ;
      endcase
    endfunction

    function void note_request(input logic [1:0] cmd, input logic [11:0] slot_v,
                               input logic [15:0] code_v, input logic [7:0] lb_v,
                               input logic [7:0] adv_v);
      int g;
      bit hit;
      placement_t p;
      case (cmd)
        CMD_LOAD_CODE: code_tab[slot_v] = code_v;
        CMD_LOAD_METRICS: begin
          bearing_tab[slot_v] = lb_v;
          advance_tab[slot_v] = adv_v;
        end
        CMD_RESET_PEN: begin
          pen_x = org_x;
          pen_y = org_y;
        end
        default: begin
          if (code_v == NEWLINE_CODE) begin
            next_line();
          end else begin
            hit = lookup(code_v, g);
            if (!hit) g = fallback;
            if (pen_x > wrap) next_line();
            p.glyph_idx = g[11:0];
            p.hit = hit;
            p.col = 11'(clamp_pos(pen_x + int'(bearing_tab[g])));
            p.row = 11'(pen_y);
            pending.insert(pending.size(), p);
            pen_x = clamp_pos(pen_x + int'(advance_tab[g]));
          end
        end
      endcase
    endfunction

    task report(input string msg);
      errors++;
      // keep the log short on a flood of errors
      if (errors <= LOG_LIMIT) $display("mismatch %0d: %s", errors, msg);
    endtask

    task check_result(input logic [11:0] g, input logic f,
                      input logic signed [10:0] x, input logic signed [10:0] y);
      placement_t p;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result glyph %0d", g));
      end else begin
        p = pending.pop_front();
        if (g !== p.glyph_idx) report($sformatf("glyph %0d, want %0d", g, p.glyph_idx));
        if (f !== p.hit) report($sformatf("found %b, want %b", f, p.hit));
        if (x !== p.col) report($sformatf("draw_x %0d, want %0d", x, p.col));
        if (y !== p.row) report($sformatf("draw_y %0d, want %0d", y, p.row));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         command = CMD_LOAD_CODE;
  logic [11:0]        slot = '0;
  logic [15:0]        code = '0;
  logic [7:0]         left_bearing = '0;
  logic [7:0]         advance = '0;
  logic               done;
  logic [11:0]        glyph;
  logic               found;
  logic signed [10:0] draw_x;
  logic signed [10:0] draw_y;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = CFG_START_X;
  logic [12:0]        cfg_data = '0;

  layout_scoreboard sb = new;
  int idle_pct = 0;
  int idle_cycles = 0;

  glyph_lookup_text_layout_top #(.MAX_GLYPHS(TABLE_DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .slot(slot), .code(code), .left_bearing(left_bearing), .advance(advance),
    .done(done), .glyph(glyph), .found(found), .draw_x(draw_x), .draw_y(draw_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // outputs are sampled mid-cycle, away from the driving edge
  always @(negedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (done === 1'b1) sb.check_result(glyph, found, draw_x, draw_y);
      if ((start && busy === 1'b0) || done === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [7:0] pick_advance();
    return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(40));
  endfunction

  // start stays high from one request to the next unless a gap is inserted
  task automatic send_request(input logic [1:0] cmd, input logic [11:0] slot_v,
                              input logic [15:0] code_v, input logic [7:0] lb_v,
                              input logic [7:0] adv_v);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    slot <= slot_v;
    code <= code_v;
    left_bearing <= lb_v;
    advance <= adv_v;
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    sb.note_request(cmd, slot_v, code_v, lb_v, adv_v);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [12:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (cfg_ready !== 1'b1);
    @(posedge clk);
    sb.note_config(idx, data);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // unused upper data bits carry junk; the block must mask them
  task automatic configure(input int sx, input int sy, input int lh, input int n,
                           input int fb, input int wl);
    logic [12:0] junk;
    drain();
    junk = 13'($urandom);
    write_reg(CFG_START_X, {junk[12:10], sx[9:0]});
    write_reg(CFG_START_Y, {junk[2:0], sy[9:0]});
    write_reg(CFG_LINE_HEIGHT, {junk[12:8], lh[7:0]});
    write_reg(CFG_GLYPH_COUNT, n[12:0]);
    write_reg(CFG_FALLBACK, {junk[5], fb[11:0]});
    write_reg(CFG_WRAP_LIMIT, {junk[9:7], wl[9:0]});
    write_reg(CFG_SPARE | 3'($urandom_range(1)), 13'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // every entry a place request can read is written before any place
  task automatic fill_tables(input int n, input bit sorted);
    int c, step, i;
    step = 60000 / (n + 1);
    if (step > 2000) step = 2000;
    c = $urandom_range(300);
    for (i = 0; i < n; i++) begin
      if (sorted) begin
        if (i > 0) c += $urandom_range(step);
        if (c > 65535) c = 65535;
      end else begin
        c = $urandom_range(65535);
      end
      send_request(CMD_LOAD_CODE, 12'(i), 16'(c), 8'($urandom), 8'($urandom));
      send_request(CMD_LOAD_METRICS, 12'(i), 16'($urandom), 8'($urandom), pick_advance());
    end
    send_request(CMD_LOAD_METRICS, 12'(sb.fallback), 16'($urandom), 8'($urandom),
                 pick_advance());
  endtask

  task automatic random_item(input int n);
    int pick, miss_pct;
    logic [15:0] c;
    logic [11:0] s;
    pick = $urandom_range(99);
    // a miss on a full table costs a scan of every entry
    miss_pct = (n > 256) ? 1 : 25;
    s = (n > 0 && $urandom_range(1)) ? 12'($urandom_range(n - 1)) : 12'($urandom);
    if (pick < 62) begin
      pick = $urandom_range(99);
      if (pick < 10) c = NEWLINE_CODE;
      else if (n > 0 && pick >= 10 + miss_pct) c = sb.code_tab[$urandom_range(n - 1)];
      else if (pick < 14) c = 16'h0000;
      else if (pick < 18) c = 16'hFFFF;
      else c = 16'($urandom);
      send_request(CMD_PLACE, 12'($urandom), c, 8'($urandom), 8'($urandom));
    end else if (pick < 77) begin
      send_request(CMD_LOAD_CODE, s, 16'($urandom), 8'($urandom), 8'($urandom));
    end else if (pick < 92) begin
      send_request(CMD_LOAD_METRICS, s, 16'($urandom), 8'($urandom), pick_advance());
    end else begin
      send_request(CMD_RESET_PEN, 12'($urandom), 16'($urandom), 8'($urandom),
                   8'($urandom));
    end
  endtask

  task automatic run_phase(input int sx, input int sy, input int lh, input int n,
                           input int fb, input int wl, input int items,
                           input bit sorted, input int idle);
    int n_used, i;
    configure(sx, sy, lh, n, fb, wl);
    n_used = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
    idle_pct = idle;
    fill_tables(n_used, sorted);
    for (i = 0; i < items; i++) random_item(n_used);
  endtask

  task automatic directed_checks();
    logic [15:0] seed_codes [6];
    int i;
    seed_codes = '{16'h0000, NEWLINE_CODE, 16'd100, 16'd100, 16'hFFFE, 16'hFFFF};
    idle_pct = 0;
    // reset config: empty table, fallback glyph 0, wrap past column 256
    send_request(CMD_LOAD_METRICS, 12'h000, 16'h0000, 8'hFF, 8'hFF);
    send_request(CMD_PLACE, 12'h000, 16'hFFFF, 8'h00, 8'h00);
    send_request(CMD_PLACE, 12'hFFF, 16'h0000, 8'hFF, 8'hFF);
    send_request(CMD_PLACE, 12'h000, 16'd1234, 8'h00, 8'h00);
    send_request(CMD_PLACE, 12'h000, NEWLINE_CODE, 8'h00, 8'h00);
    send_request(CMD_RESET_PEN, 12'h000, 16'h0000, 8'h00, 8'h00);
    configure(-512, 511, 255, 6, 5, 0);
    for (i = 0; i < 6; i++) begin
      send_request(CMD_LOAD_CODE, 12'(i), seed_codes[i], 8'h00, 8'h00);
      send_request(CMD_LOAD_METRICS, 12'(i), 16'h0000, 8'(i * 51), (i == 5) ? 8'h00 : 8'hFF);
    end
    // duplicate code, both ends of the code range, a miss, y saturation
    send_request(CMD_PLACE, 12'h000, 16'h0000, 8'h00, 8'h00);
    send_request(CMD_PLACE, 12'h000, 16'd100, 8'h00, 8'h00);
    send_request(CMD_PLACE, 12'h000, 16'hFFFE, 8'h00, 8'h00);
    send_request(CMD_PLACE, 12'h000, 16'hFFFF, 8'h00, 8'h00);
    send_request(CMD_PLACE, 12'h000, 16'd7, 8'h00, 8'h00);
    send_request(CMD_PLACE, 12'h000, NEWLINE_CODE, 8'h00, 8'h00);
    send_request(CMD_PLACE, 12'h000, 16'hFFFF, 8'h00, 8'h00);
    send_request(CMD_RESET_PEN, 12'h000, 16'h0000, 8'h00, 8'h00);
    // unsorted entry: the first binary search probe finds it
    send_request(CMD_LOAD_CODE, 12'h002, 16'd1, 8'h00, 8'h00);
    send_request(CMD_PLACE, 12'h000, 16'd1, 8'h00, 8'h00);
  endtask

  initial begin : stimulus
    int k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    directed_checks();
    run_phase(0, 0, 16, 16, 3, 256, 100, 1'b1, 0);
    run_phase(-512, -512, 255, 1, 4095, 0, 80, 1'b1, 66);
    run_phase(511, 511, 0, 64, 0, 1023, 120, 1'b0, 22);
    run_phase(0, 0, 16, 0, 4095, 300, 40, 1'b1, 66);
    for (k = 0; k < 5; k++) begin
      run_phase(int'($urandom_range(1023)) - 512, int'($urandom_range(1023)) - 512,
                $urandom_range(255), $urandom_range(1, 24), $urandom_range(4095),
                $urandom_range(1023), 40, k[0], (k % 3 == 0) ? 0 : (k % 3 == 1) ? 66 : 22);
    end
    drain();
    repeat (40) @(posedge clk);
    if (sb.pending.size() != 0) sb.report($sformatf("%0d results never came", sb.pending.size()));
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: glyph_lookup_text_layout_top.f
sv/glt_pkg.sv
sv/glt_cfg.sv
sv/glt_ctrl.sv
sv/glt_dp.sv
sv/glyph_lookup_text_layout_top.sv
bench/testbench.sv
